FILE: hdl/rbst_pkg.sv
package rbst_pkg;

  // Item and register widths.
  localparam int unsigned FP_W      = 32;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned IN_W      = 224;
  localparam int unsigned OUT_W     = 72;
  localparam int unsigned CFG_IDX_W = 3;

  // Fixed bit patterns.
  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] GROW_BITS = 32'h3F80_0003;
  localparam logic [31:0] FP_ZERO   = 32'h0000_0000;

  // Pipeline depths.
  localparam int unsigned ADD_LAT   = 3;
  localparam int unsigned MUL_LAT   = 3;
  localparam int unsigned DIV_STEPS = 25;
  localparam int unsigned REC_LAT   = DIV_STEPS + 2;
  localparam int unsigned LANE_LAT  = REC_LAT + MUL_LAT + 1 + MUL_LAT;
  localparam int unsigned MERGE_LAT = 3;
  localparam int unsigned PIPE_LAT  = LANE_LAT + MERGE_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

  // Unrounded value: bit 25 of mant is the leading one, bit 1 round, bit 0 sticky.
  typedef struct packed {
    logic               sign;
    logic signed [10:0] exp;
    logic [25:0]        mant;
  } fp_unr_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    fp_unr_t     u;
  } fp_mid_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_sum_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] exp;
    logic [47:0]        prod;
  } mul_prod_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] exp;
    logic [23:0]        mn;
    logic [25:0]        r;
    logic [24:0]        q;
  } rec_state_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] a);
    return a[30:0] == 31'b0;
  endfunction

  // Ordered greater-than; false when either side is NaN, and signed zeros are equal.
  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return !fp_is_nan(a) && !fp_is_nan(b) && !(fp_is_zero(a) && fp_is_zero(b)) && (ka > kb);
  endfunction

  // Round to nearest even and pack, including subnormal and overflow results.
  function automatic logic [31:0] round_pack(input fp_unr_t u);
    logic [25:0]        m;
    logic [4:0]         sh;
    logic signed [11:0] shw;
    logic signed [11:0] e;
    logic               inc;
    logic               sub;
    logic [24:0]        sum;
    logic [31:0]        res;
    m   = u.mant;
    sh  = 5'd0;
    shw = 12'sd1 - $signed({u.exp[10], u.exp});
    sub = $signed(u.exp) < 11'sd1;
    if (sub) begin
      if (shw > 12'sd26) begin
        sh = 5'd26;
      end else begin
        sh = shw[4:0];
      end
      m = (u.mant >> sh) | {25'b0, |(u.mant & ~({26{1'b1}} << sh))};
    end
    inc = m[1] & (m[0] | m[2]);
    sum = {1'b0, m[25:2]} + {24'b0, inc};
    e   = $signed({u.exp[10], u.exp}) + $signed({11'b0, sum[24]});
    if (u.mant == 26'b0) begin
      res = {u.sign, 31'b0};
    end else if (sub) begin
      res = {u.sign, 7'b0, sum[23:0]};
    end else if (e >= 12'sd255) begin
      res = {u.sign, 8'hFF, 23'b0};
    end else begin
      res = {u.sign, e[7:0], sum[22:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_finish(input fp_mid_t m);
    return m.spec ? m.spec_val : round_pack(m.u);
  endfunction

  // Adder, first step: special cases, order by magnitude, align and add with guard, round, sticky.
  function automatic add_sum_t add_align(input logic [31:0] a, input logic [31:0] b);
    logic        swp;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [23:0] mx;
    logic [23:0] my;
    logic [26:0] sm;
    logic [26:0] shm;
    logic        stk;
    logic        eff_sub;
    logic [27:0] sum;
    add_sum_t    r;
    swp = b[30:0] > a[30:0];
    x   = swp ? b : a;
    y   = swp ? a : b;
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx  = {x[30:23] != 8'd0, x[22:0]};
    my  = {y[30:23] != 8'd0, y[22:0]};
    d   = ex - ey;
    sm  = {my, 3'b0};
    if (d > 8'd26) begin
      shm = 27'b0;
      stk = |sm;
    end else begin
      shm = sm >> d;
      stk = |(sm & ~({27{1'b1}} << d));
    end
    shm[0]  = shm[0] | stk;
    eff_sub = x[31] ^ y[31];
    sum = eff_sub ? ({1'b0, mx, 3'b0} - {1'b0, shm}) : ({1'b0, mx, 3'b0} + {1'b0, shm});
    r.sign = (eff_sub && (sum == 28'b0)) ? 1'b0 : x[31];
    r.exp  = ex;
    r.sum  = sum;
    r.spec = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      r.spec_val = QNAN;
    end else if (fp_is_inf(x) && fp_is_inf(y) && eff_sub) begin
      r.spec_val = QNAN;
    end else if (fp_is_inf(x)) begin
      r.spec_val = x;
    end else begin
      r.spec     = 1'b0;
      r.spec_val = x;
    end
    return r;
  endfunction

  // Adder, second step: normalize the sum.
  function automatic fp_mid_t add_norm(input add_sum_t s);
    logic [26:0]        n;
    logic [4:0]         lz;
    logic signed [10:0] e;
    fp_mid_t            r;
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s.sum[i]) lz = 5'(26 - i);
    end
    e = $signed({3'b0, s.exp});
    if (s.sum[27]) begin
      n = {s.sum[27:2], s.sum[1] | s.sum[0]};
      e = e + 11'sd1;
    end else begin
      n = s.sum[26:0] << lz;
      e = e - $signed({6'b0, lz});
    end
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    r.u.sign   = s.sign;
    r.u.exp    = e;
    r.u.mant   = {n[26:2], |n[1:0]};
    return r;
  endfunction

  // Multiplier, first step: special cases and the mantissa product.
  function automatic mul_prod_t mul_core(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        s;
    mul_prod_t   r;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    r.sign = s;
    r.exp  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
    r.prod = ma * mb;
    r.spec = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      r.spec_val = QNAN;
    end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
      r.spec_val = QNAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      r.spec_val = {s, 8'hFF, 23'b0};
    end else if (fp_is_zero(a) || fp_is_zero(b)) begin
      r.spec_val = {s, 31'b0};
    end else begin
      r.spec     = 1'b0;
      r.spec_val = FP_ZERO;
    end
    return r;
  endfunction

  // Multiplier, second step: normalize the product.
  function automatic fp_mid_t mul_norm(input mul_prod_t p);
    logic [47:0] n;
    logic [5:0]  lz;
    fp_mid_t     r;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p.prod[i]) lz = 6'(47 - i);
    end
    n          = p.prod << lz;
    r.spec     = p.spec;
    r.spec_val = p.spec_val;
    r.u.sign   = p.sign;
    r.u.exp    = $signed(p.exp) - $signed({5'b0, lz});
    r.u.mant   = {n[47:23], |n[22:0]};
    return r;
  endfunction

  // Reciprocal setup: normalize the divisor and pick the first partial remainder.
  function automatic rec_state_t rec_prep(input logic [31:0] d);
    logic [23:0] md;
    logic [7:0]  ed;
    logic [4:0]  lz;
    logic        pow;
    rec_state_t  r;
    md = {d[30:23] != 8'd0, d[22:0]};
    ed = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (md[i]) lz = 5'(23 - i);
    end
    r.mn   = md << lz;
    pow    = r.mn[22:0] == 23'b0;
    r.r    = pow ? 26'h080_0000 : 26'h100_0000;
    r.q    = 25'b0;
    r.sign = d[31];
    r.exp  = 11'sd253 + $signed({10'b0, pow}) - ($signed({3'b0, ed}) - $signed({6'b0, lz}));
    r.spec = 1'b1;
    if (fp_is_nan(d)) begin
      r.spec_val = QNAN;
    end else if (fp_is_zero(d)) begin
      r.spec_val = {d[31], 8'hFF, 23'b0};
    end else if (fp_is_inf(d)) begin
      r.spec_val = {d[31], 31'b0};
    end else begin
      r.spec     = 1'b0;
      r.spec_val = FP_ZERO;
    end
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic rec_state_t rec_step(input rec_state_t s);
    logic       ge;
    rec_state_t r;
    r  = s;
    ge = s.r >= {2'b0, s.mn};
    r.q = {s.q[23:0], ge};
    r.r = (ge ? (s.r - {2'b0, s.mn}) : s.r) << 1;
    return r;
  endfunction

  function automatic fp_mid_t rec_final(input rec_state_t s);
    fp_mid_t r;
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    r.u.sign   = s.sign;
    r.u.exp    = s.exp;
    r.u.mant   = {s.q, s.r != 26'b0};
    return r;
  endfunction

endpackage

FILE: hdl/ray_box_slab_test.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one ray per item
// m_axis    out        m_axis_tvalid / m_axis_tready  hit flag and interval per item
// cfg       in         cfg_we_i (no wait)             box corner registers
//
// One ray is accepted every cycle while the pipeline is not holding.
// Most of the depth comes from the 25-step reciprocal divider in each axis lane.
// Reset clears the box registers to zero and empties the pipeline.
// When a result waits and the last pipeline stage is full, the whole pipeline holds.
module ray_box_slab_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit
  input  logic [rbst_pkg::IN_W-1:0]           s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // hit, t_enter, t_exit, zero fill
  output logic [rbst_pkg::OUT_W-1:0]          m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [rbst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbst_pkg::FP_W-1:0]           cfg_data_i
);
  import rbst_pkg::*;

  logic [31:0]         box_min_q [NUM_AXES];
  logic [31:0]         box_max_q [NUM_AXES];
  logic [PIPE_LAT-1:0] vld_q;
  logic                adv;
  logic [31:0]         tl_q [LANE_LAT];
  logic [31:0]         t_near [NUM_AXES];
  logic [31:0]         t_far  [NUM_AXES];
  logic                hit;
  logic [31:0]         t_enter;
  logic [31:0]         t_exit;
  logic                out_vld_q;
  logic [OUT_W-1:0]    out_data_q;

  // Box registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_min_q[i] <= FP_ZERO;
        box_max_q[i] <= FP_ZERO;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless its last stage is full and the output is blocked.
  assign adv           = !(vld_q[PIPE_LAT-1] && out_vld_q && !m_axis_tready);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // The ray limit waits for the lanes.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tl_q[0] <= s_axis_tdata[6*FP_W +: FP_W];
      for (int i = 1; i < LANE_LAT; i++) begin
        tl_q[i] <= tl_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    rbst_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .box_lo_i (box_min_q[k]),
      .box_hi_i (box_max_q[k]),
      .org_i    (s_axis_tdata[k*FP_W +: FP_W]),
      .dir_i    (s_axis_tdata[(NUM_AXES+k)*FP_W +: FP_W]),
      .t_near_o (t_near[k]),
      .t_far_o  (t_far[k])
    );
  end

  rbst_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (adv),
    .t_near_i  (t_near),
    .t_far_i   (t_far),
    .t_limit_i (tl_q[LANE_LAT-1]),
    .hit_o     (hit),
    .t_enter_o (t_enter),
    .t_exit_o  (t_exit)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (vld_q[PIPE_LAT-1] && adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[PIPE_LAT-1] && adv) begin
      out_data_q <= {(OUT_W - 2*FP_W - 1)'(0), t_exit, t_enter, hit};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // An empty last stage never blocks the input.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[PIPE_LAT-1] |-> s_axis_tready)
    else $error("input blocked while the last stage is empty");

  // A miss carries zero distances.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[2*FP_W:1] == '0))
    else $error("miss with nonzero distances");

  // An accepted item enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item lost at the first stage");

  // A stall freezes the stage occupancy.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule

FILE: hdl/rbst_fadd.sv
module rbst_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);
  import rbst_pkg::*;

  add_sum_t    s1_q;
  fp_mid_t     s2_q;
  logic [31:0] s3_q;

  // Align and add, normalize, then round.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= add_align(a_i, b_i);
      s2_q <= add_norm(s1_q);
      s3_q <= fp_finish(s2_q);
    end
  end

  assign sum_o = s3_q;

endmodule

FILE: hdl/rbst_fmul.sv
module rbst_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);
  import rbst_pkg::*;

  mul_prod_t   s1_q;
  fp_mid_t     s2_q;
  logic [31:0] s3_q;

  // Multiply mantissas, normalize, then round.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= mul_core(a_i, b_i);
      s2_q <= mul_norm(s1_q);
      s3_q <= fp_finish(s2_q);
    end
  end

  assign prod_o = s3_q;

endmodule

FILE: hdl/rbst_recip.sv
module rbst_recip (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] d_i,
  output logic [31:0] inv_o
);
  import rbst_pkg::*;

  rec_state_t  st_q [DIV_STEPS+1];
  logic [31:0] out_q;

  // Setup stage, one quotient bit per stage, then rounding.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= rec_prep(d_i);
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_q[k+1] <= rec_step(st_q[k]);
      end
      out_q <= fp_finish(rec_final(st_q[DIV_STEPS]));
    end
  end

  assign inv_o = out_q;

endmodule

FILE: hdl/rbst_lane.sv
module rbst_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] box_lo_i,
  input  logic [31:0] box_hi_i,
  input  logic [31:0] org_i,
  input  logic [31:0] dir_i,
  output logic [31:0] t_near_o,
  output logic [31:0] t_far_o
);
  import rbst_pkg::*;

  localparam int unsigned DiffDly = REC_LAT - ADD_LAT;

  logic [31:0] near_diff;
  logic [31:0] far_diff;
  logic [31:0] inv;
  logic [31:0] near_prod;
  logic [31:0] far_prod;
  logic [31:0] near_dly_q [DiffDly];
  logic [31:0] far_dly_q  [DiffDly];
  logic [31:0] near_q;
  logic [31:0] far_q;
  logic [31:0] near_hold_q [MUL_LAT];

  // Slab offsets from the origin.
  rbst_fadd u_near_sub (
    .clk_i (clk_i), .en_i (en_i),
    .a_i   (box_lo_i), .b_i ({~org_i[31], org_i[30:0]}),
    .sum_o (near_diff)
  );

  rbst_fadd u_far_sub (
    .clk_i (clk_i), .en_i (en_i),
    .a_i   (box_hi_i), .b_i ({~org_i[31], org_i[30:0]}),
    .sum_o (far_diff)
  );

  rbst_recip u_recip (
    .clk_i (clk_i), .en_i (en_i),
    .d_i   (dir_i),
    .inv_o (inv)
  );

  // Hold the offsets until the reciprocal is ready.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_dly_q[0] <= near_diff;
      far_dly_q[0]  <= far_diff;
      for (int i = 1; i < DiffDly; i++) begin
        near_dly_q[i] <= near_dly_q[i-1];
        far_dly_q[i]  <= far_dly_q[i-1];
      end
    end
  end

  rbst_fmul u_near_mul (
    .clk_i  (clk_i), .en_i (en_i),
    .a_i    (near_dly_q[DiffDly-1]), .b_i (inv),
    .prod_o (near_prod)
  );

  rbst_fmul u_far_mul (
    .clk_i  (clk_i), .en_i (en_i),
    .a_i    (far_dly_q[DiffDly-1]), .b_i (inv),
    .prod_o (far_prod)
  );

  // Put the two distances in order.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fp_gt(near_prod, far_prod)) begin
        near_q <= far_prod;
        far_q  <= near_prod;
      end else begin
        near_q <= near_prod;
        far_q  <= far_prod;
      end
    end
  end

  // Widen the far distance to cover rounding error.
  rbst_fmul u_grow_mul (
    .clk_i  (clk_i), .en_i (en_i),
    .a_i    (far_q), .b_i (GROW_BITS),
    .prod_o (t_far_o)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_hold_q[0] <= near_q;
      for (int i = 1; i < MUL_LAT; i++) begin
        near_hold_q[i] <= near_hold_q[i-1];
      end
    end
  end

  assign t_near_o = near_hold_q[MUL_LAT-1];

endmodule

FILE: hdl/rbst_merge.sv
module rbst_merge (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] t_near_i [rbst_pkg::NUM_AXES],
  input  logic [31:0] t_far_i  [rbst_pkg::NUM_AXES],
  input  logic [31:0] t_limit_i,
  output logic        hit_o,
  output logic [31:0] t_enter_o,
  output logic [31:0] t_exit_o
);
  import rbst_pkg::*;

  logic [31:0] lo_q [MERGE_LAT];
  logic [31:0] hi_q [MERGE_LAT];
  logic [31:0] ny_q;
  logic [31:0] fy_q;
  logic [31:0] nz_q [2];
  logic [31:0] fz_q [2];

  // Narrow the interval one axis per stage; later axes wait in line.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q[0] <= fp_gt(t_near_i[0], FP_ZERO) ? t_near_i[0] : FP_ZERO;
      hi_q[0] <= fp_gt(t_limit_i, t_far_i[0]) ? t_far_i[0] : t_limit_i;
      ny_q    <= t_near_i[1];
      fy_q    <= t_far_i[1];
      nz_q[0] <= t_near_i[2];
      fz_q[0] <= t_far_i[2];
      lo_q[1] <= fp_gt(ny_q, lo_q[0]) ? ny_q : lo_q[0];
      hi_q[1] <= fp_gt(hi_q[0], fy_q) ? fy_q : hi_q[0];
      nz_q[1] <= nz_q[0];
      fz_q[1] <= fz_q[0];
      lo_q[2] <= fp_gt(nz_q[1], lo_q[1]) ? nz_q[1] : lo_q[1];
      hi_q[2] <= fp_gt(hi_q[1], fz_q[1]) ? fz_q[1] : hi_q[1];
    end
  end

  // The interval only shrinks, so an empty final interval means a miss.
  assign hit_o     = !fp_gt(lo_q[MERGE_LAT-1], hi_q[MERGE_LAT-1]);
  assign t_enter_o = hit_o ? lo_q[MERGE_LAT-1] : FP_ZERO;
  assign t_exit_o  = hit_o ? hi_q[MERGE_LAT-1] : FP_ZERO;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rbst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;

  // One ray as it travels in s_axis_tdata.
  typedef struct packed {
    logic [31:0] t_limit;
    logic [31:0] dir_z;
    logic [31:0] dir_y;
    logic [31:0] dir_x;
    logic [31:0] origin_z;
    logic [31:0] origin_y;
    logic [31:0] origin_x;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_enter;
    logic [31:0] t_exit;
  } hit_t;

  // Single precision arithmetic done through doubles. Each finite operation is
  // exact or correctly rounded in double, so one final rounding to single
  // gives the IEEE result.
  class slab_hit_book;
    logic [31:0] box_lo[3];
    logic [31:0] box_hi[3];
    hit_t        pending_hits[$];
    int          failures;

    function new();
      failures = 0;
      foreach (box_lo[i]) begin
        box_lo[i] = FP_ZERO;
        box_hi[i] = FP_ZERO;
      end
    endfunction

    function void set_corner(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        REG_MIN_X: box_lo[0] = v;
        REG_MIN_Y: box_lo[1] = v;
        REG_MIN_Z: box_lo[2] = v;
        REG_MAX_X: box_hi[0] = v;
        REG_MAX_Y: box_hi[1] = v;
        REG_MAX_Z: box_hi[2] = v;
        default: ;
      endcase
    endfunction

    static function bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    static function bit is_inf(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 0;
    endfunction

    static function bit is_zero(logic [31:0] a);
      return a[30:0] == 0;
    endfunction

    static function real widen(logic [31:0] a);
      real v;
      if (a[30:23] == 8'hFF) return $bitstoreal({a[31], 11'h7FF, a[22:0], 29'b0});
      if (a[30:23] == 8'h00) begin
        if (a[22:0] == 0) return $bitstoreal({a[31], 63'b0});
        v = $itor(a[22:0]) * (2.0 ** (-149));
        return a[31] ? -v : v;
      end
      return $bitstoreal({a[31], 11'(a[30:23] - 127 + 1023), a[22:0], 29'b0});
    endfunction

    // Round a finite double to single, nearest even, with subnormals and overflow.
    static function logic [31:0] narrow(real r);
      logic [63:0] b;
      logic [63:0] m;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      b = $realtobits(r);
      if (b[62:0] == 0) return {b[63], 31'b0};
      e = int'(b[62:52]) - 1023;
      m = {11'b0, 1'b1, b[51:0]};
      if (e > 127) return {b[63], 8'hFF, 23'b0};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) return {b[63], 31'b0};
      kept = m >> sh;
      rem  = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      if (e >= -126) begin
        if (kept[24]) begin
          kept = kept >> 1;
          e = e + 1;
        end
        if (e > 127) return {b[63], 8'hFF, 23'b0};
        return {b[63], 8'(e + 127), kept[22:0]};
      end
      return {b[63], kept[30:0]};
    endfunction

    static function logic [31:0] f_sub(logic [31:0] a, logic [31:0] bb);
      logic [31:0] b;
      b = {~bb[31], bb[30:0]};
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      return narrow(widen(a) + widen(b));
    endfunction

    static function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return QNAN;
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return QNAN;
      if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'b0};
      return narrow(widen(a) * widen(b));
    endfunction

    static function logic [31:0] f_recip(logic [31:0] d);
      if (is_nan(d)) return QNAN;
      if (is_zero(d)) return {d[31], 8'hFF, 23'b0};
      if (is_inf(d)) return {d[31], 31'b0};
      return narrow(1.0 / widen(d));
    endfunction

    static function bit f_gt(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 0;
      return widen(a) > widen(b);
    endfunction

    // Narrow the interval by one axis; returns 0 once it is empty.
    function bit clip_axis(int ax, logic [31:0] org, logic [31:0] dir,
                           inout logic [31:0] lo, inout logic [31:0] hi);
      logic [31:0] inv;
      logic [31:0] tn;
      logic [31:0] tf;
      logic [31:0] tmp;
      inv = f_recip(dir);
      tn  = f_mul(f_sub(box_lo[ax], org), inv);
      tf  = f_mul(f_sub(box_hi[ax], org), inv);
      if (f_gt(tn, tf)) begin
        tmp = tn;
        tn  = tf;
        tf  = tmp;
      end
      tf = f_mul(tf, GROW_BITS);
      if (f_gt(tn, lo)) lo = tn;
      if (f_gt(hi, tf)) hi = tf;
      return !f_gt(lo, hi);
    endfunction

    function void note_ray(ray_t r);
      logic [31:0] lo;
      logic [31:0] hi;
      bit          hit;
      hit_t        h;
      lo  = FP_ZERO;
      hi  = r.t_limit;
      hit = clip_axis(0, r.origin_x, r.dir_x, lo, hi);
      if (hit) hit = clip_axis(1, r.origin_y, r.dir_y, lo, hi);
      if (hit) hit = clip_axis(2, r.origin_z, r.dir_z, lo, hi);
      h.hit     = hit;
      h.t_enter = hit ? lo : FP_ZERO;
      h.t_exit  = hit ? hi : FP_ZERO;
      pending_hits.push_back(h);
    endfunction

    function void check_hit(logic [OUT_W-1:0] d);
      hit_t exp_h;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        failures++;
        return;
      end
      exp_h = pending_hits.pop_front();
      if (d[0] !== exp_h.hit || d[32:1] !== exp_h.t_enter || d[64:33] !== exp_h.t_exit ||
          d[OUT_W-1:65] !== '0) begin
        $display("%0t: mismatch expected hit=%b enter=%h exit=%h, actual hit=%b enter=%h exit=%h",
                 $time, exp_h.hit, exp_h.t_enter, exp_h.t_exit, d[0], d[32:1], d[64:33]);
        failures++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [FP_W-1:0]      cfg_data_i = '0;

  slab_hit_book book = new();
  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;
  bit           hold_req = 0;
  bit           hold_taken = 0;
  int unsigned  hold_left = 0;
  int unsigned  cycles = 0;

  ray_box_slab_test uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checking and the run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_hit(m_axis_tdata);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    logic [31:0] vals[6];
    vals = '{lx, ly, lz, hx, hy, hz};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      book.set_corner(cfg_reg_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_ray(r);
    @(negedge clk_i);
  endtask

  // Wait until every result has come and the pipeline has drained.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (book.pending_hits.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 10) @(negedge clk_i);
  endtask

  // A float of moderate size, now and then zero, subnormal, infinite or NaN.
  function automatic logic [31:0] some_float();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 3) return {1'($urandom), 31'b0};
    if (k < 5) return {1'($urandom), 8'hFF, 23'b0};
    if (k < 6) return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
    if (k < 8) return {1'($urandom), 8'h00, 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(99) < 75) begin
      r.origin_x = some_float();
      r.origin_y = some_float();
      r.origin_z = some_float();
      r.dir_x    = some_float();
      r.dir_y    = some_float();
      r.dir_z    = some_float();
      case ($urandom_range(3))
        0: r.t_limit = 32'h7F80_0000;
        1: r.t_limit = {1'b0, 8'($urandom_range(120, 140)), 23'($urandom)};
        default: r.t_limit = some_float();
      endcase
    end
    return r;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_ray(random_ray());
  endtask

  function automatic ray_t mk_ray(logic [31:0] o, logic [31:0] d, logic [31:0] t);
    ray_t r;
    r = '{t, d, d, d, o, o, o};
    return r;
  endfunction

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rays against the reset box, then against a unit box.
    send_idle = 21;
    recv_idle = 53;
    send_ray(mk_ray(32'h0, 32'h3F80_0000, 32'h7F80_0000));
    drain();
    write_box(32'hBF80_0000, 32'hBF80_0000, 32'hBF80_0000,
              32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_ray(mk_ray(32'hC000_0000, 32'h3F80_0000, 32'h7F80_0000)); // hits
    send_ray(mk_ray(32'hC000_0000, 32'h0000_0000, 32'h7F80_0000)); // zero direction
    send_ray(mk_ray(32'hC000_0000, 32'h8000_0000, 32'h7F80_0000)); // negative zero
    send_ray(mk_ray(32'h0, 32'h0, 32'h7F80_0000));                 // inside, no motion
    send_ray(mk_ray(32'h0, 32'h3F80_0000, 32'h7FC0_0000));         // NaN limit
    send_ray(mk_ray(32'h0, 32'h3F80_0000, 32'hFFC0_0001));         // negative NaN limit
    send_ray(mk_ray(32'h7FC0_0000, 32'h3F80_0000, 32'h7F80_0000)); // NaN origin
    send_ray(mk_ray(32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000)); // infinite origin
    send_ray(mk_ray(32'hC000_0000, 32'h7F80_0000, 32'h7F80_0000)); // infinite direction
    send_ray(mk_ray(32'hC000_0000, 32'h0000_0001, 32'h7F80_0000)); // tiny direction
    send_ray(mk_ray(32'hC000_0000, 32'h7F7F_FFFF, 32'h7F80_0000)); // huge direction
    send_ray(mk_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ray(mk_ray(32'h0, 32'h0, 32'h0));
    send_ray(mk_ray(32'hC000_0000, 32'h3F80_0000, 32'h3F00_0000)); // limit too short
    send_ray(mk_ray(32'h4000_0000, 32'h3F80_0000, 32'h7F80_0000)); // box behind
    send_ray(mk_ray(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF));
    send_ray(mk_ray(32'h0000_0001, 32'h8000_0001, 32'h0000_0001));
    run_random(150);
    drain();

    // Inverted box.
    write_box(32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
              32'hC000_0000, 32'hC000_0000, 32'hC000_0000);
    run_random(200);
    drain();

    // Infinite extent.
    write_box(32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000,
              32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000);
    run_random(200);
    drain();

    // Swap the idle pattern. NaN corners, then largest finite and tiny corners, then a random box.
    send_idle = 53;
    recv_idle = 21;
    write_box(32'hFFFF_FFFF, 32'h7FC0_0000, 32'h0000_0000,
              32'hFFFF_FFFF, 32'h7FC0_0000, 32'h7F80_0000);
    run_random(150);
    drain();
    write_box(32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0000,
              32'h7F7F_FFFF, 32'h8000_0001, 32'h0000_0000);
    run_random(200);
    drain();
    write_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(150);
    drain();

    // No idling; a long receiver hold-off fills the pipeline.
    send_idle = 0;
    recv_idle = 0;
    write_box(some_float(), some_float(), some_float(),
              some_float(), some_float(), some_float());
    hold_req = 1;
    run_random(250);
    drain();
    write_box(32'hBF80_0000, 32'hC000_0000, 32'hC040_0000,
              32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
    run_random(250);
    drain();

    if (book.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
